[hdl/mtep_pkg.sv]
// ---------------------------------------------------------------------------
// mtep_pkg: shared types and constants of the track event parser
// Parse phases, event kinds, parser state and result records.
// ---------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

  typedef enum logic [7:0] {
    PH_DELTA  = 8'b0000_0001,
    PH_STATUS = 8'b0000_0010,
    PH_DATA1  = 8'b0000_0100,
    PH_DATA2  = 8'b0000_1000,
    PH_MTYPE  = 8'b0001_0000,
    PH_MLEN   = 8'b0010_0000,
    PH_TEMPO  = 8'b0100_0000,
    PH_SKIP   = 8'b1000_0000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NOTE_OFF       = 3'd0,
    EV_NOTE_ON        = 3'd1,
    EV_SILENT         = 3'd2,
    EV_TEMPO          = 3'd3,
    EV_END_OF_TRACK   = 3'd4,
    EV_MISSING_STATUS = 3'd5
  } kind_t;

  localparam logic [7:0] META_END_OF_TRACK = 8'h2f;
  localparam logic [7:0] META_TEMPO        = 8'h51;
  localparam logic [4:0] SILENT_CH_RESET   = 5'd9;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] delta_accum;
    logic [7:0]  running_status;
    logic [7:0]  current_status;
    logic [6:0]  first_data;
    logic [7:0]  meta_type;
    logic [31:0] meta_remaining;
    logic [31:0] tempo_accum;
    logic [2:0]  tempo_bytes_taken;
    logic        track_done;
  } parse_state_t;

  localparam parse_state_t PARSE_CLEAR = '{
    phase:             PH_DELTA,
    delta_accum:       32'd0,
    running_status:    8'd0,
    current_status:    8'd0,
    first_data:        7'd0,
    meta_type:         8'd0,
    meta_remaining:    32'd0,
    tempo_accum:       32'd0,
    tempo_bytes_taken: 3'd0,
    track_done:        1'b0
  };

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [5:0]  volume;
    logic [31:0] delta_time;
    logic [31:0] tempo_value;
  } result_t;

endpackage

`default_nettype wire

[hdl/mtep_step.sv]
// ---------------------------------------------------------------------------
// mtep_step: one-byte parse step
// Next parser state and the optional event for one track byte.
// ---------------------------------------------------------------------------
`default_nettype none

module mtep_step
  import mtep_pkg::*;
(
  input  parse_state_t cur,
  input  logic         track_start,
  input  logic [7:0]   data_byte,
  input  logic [4:0]   silent_channel,
  output parse_state_t nxt,
  output result_t      res
);

  // 2*y/7 by reciprocal multiply, one correction step
  function automatic logic [5:0] volume_of(input logic [6:0] y);
    logic [7:0]  x;
    logic [14:0] p;
    logic [5:0]  q;
    logic [8:0]  r;
    x = {y, 1'b0};
    p = {7'd0, x} * 15'd73;
    q = p[14:9];
    r = {1'b0, x} - ({3'd0, q} * 9'd7);
    if (r >= 9'd7) begin
      q = q + 6'd1;
    end
    return q;
  endfunction

  parse_state_t s0;
  logic [7:0]   b;
  logic [6:0]   b7;
  logic [31:0]  rem_dec;
  logic [31:0]  tempo_sh;
  logic [2:0]   taken_inc;
  logic [31:0]  mlen_sh;
  logic [7:0]   first_st;

  assign s0        = track_start ? PARSE_CLEAR : cur;
  assign b         = data_byte;
  assign b7        = data_byte[6:0];
  assign rem_dec   = s0.meta_remaining - 32'd1;
  assign tempo_sh  = {s0.tempo_accum[23:0], b};
  assign taken_inc = s0.tempo_bytes_taken + 3'd1;
  assign mlen_sh   = {s0.meta_remaining[24:0], b7};
  // status seen by the first data byte: running status when it is reused
  assign first_st  = (s0.phase == PH_STATUS) ? s0.running_status : s0.current_status;

  always_comb begin
    nxt = s0;
    res = '{valid: 1'b0, kind: EV_NOTE_OFF, channel: 4'd0, note: 7'd0, velocity: 7'd0,
            volume: 6'd0, delta_time: s0.delta_accum, tempo_value: 32'd0};

    if (!s0.track_done) begin
      case (s0.phase)
        PH_STATUS: begin
          if (b[7]) begin
            nxt.current_status = b;
            if (b[7:4] != 4'hf) begin
              nxt.running_status = b;
              nxt.phase = PH_DATA1;
            end else if (b[3:0] == 4'hf) begin
              nxt.phase = PH_MTYPE;
            end else begin
              if (!b[3]) begin
                nxt.running_status = 8'd0;
              end
              nxt.phase = PH_DELTA;
              nxt.delta_accum = 32'd0;
            end
          end else if (s0.running_status[7]) begin
            nxt.current_status = s0.running_status;
            if (first_st[7:4] == 4'hc || first_st[7:4] == 4'hd) begin
              nxt.phase = PH_DELTA;
              nxt.delta_accum = 32'd0;
            end else begin
              nxt.first_data = b7;
              nxt.phase = PH_DATA2;
            end
          end else begin
            // data byte with no status: flag it, byte becomes next delta
            res.valid = 1'b1;
            res.kind = EV_MISSING_STATUS;
            nxt.delta_accum = {24'd0, b};
            nxt.phase = PH_STATUS;
          end
        end
        PH_DATA1: begin
          if (first_st[7:4] == 4'hc || first_st[7:4] == 4'hd) begin
            nxt.phase = PH_DELTA;
            nxt.delta_accum = 32'd0;
          end else begin
            nxt.first_data = b7;
            nxt.phase = PH_DATA2;
          end
        end
        PH_DATA2: begin
          res.channel = s0.current_status[3:0];
          res.note = s0.first_data;
          res.velocity = b7;
          if (s0.current_status[7:4] == 4'h8) begin
            res.valid = 1'b1;
            res.kind = EV_NOTE_OFF;
          end else if (s0.current_status[7:4] == 4'h9) begin
            res.valid = 1'b1;
            if ({1'b0, s0.current_status[3:0]} == silent_channel) begin
              res.kind = EV_SILENT;
            end else if (b7 == 7'd0) begin
              res.kind = EV_NOTE_OFF;
            end else begin
              res.kind = EV_NOTE_ON;
              res.volume = volume_of(b7);
            end
          end
          nxt.phase = PH_DELTA;
          nxt.delta_accum = 32'd0;
        end
        PH_MTYPE: begin
          nxt.meta_type = b;
          nxt.meta_remaining = 32'd0;
          nxt.phase = PH_MLEN;
        end
        PH_MLEN: begin
          nxt.meta_remaining = mlen_sh;
          if (!b[7]) begin
            if (s0.meta_type == META_END_OF_TRACK) begin
              res.valid = 1'b1;
              res.kind = EV_END_OF_TRACK;
              nxt.phase = PH_DELTA;
              nxt.delta_accum = 32'd0;
              nxt.track_done = 1'b1;
            end else if (s0.meta_type == META_TEMPO) begin
              nxt.tempo_accum = 32'd0;
              nxt.tempo_bytes_taken = 3'd0;
              if (mlen_sh == 32'd0) begin
                res.valid = 1'b1;
                res.kind = EV_TEMPO;
                res.tempo_value = 32'd1;
                nxt.phase = PH_DELTA;
                nxt.delta_accum = 32'd0;
              end else begin
                nxt.phase = PH_TEMPO;
              end
            end else if (mlen_sh == 32'd0) begin
              nxt.phase = PH_DELTA;
              nxt.delta_accum = 32'd0;
            end else begin
              nxt.phase = PH_SKIP;
            end
          end
        end
        PH_TEMPO: begin
          nxt.tempo_accum = tempo_sh;
          nxt.tempo_bytes_taken = taken_inc;
          nxt.meta_remaining = rem_dec;
          if (rem_dec == 32'd0 || taken_inc >= 3'd4) begin
            res.valid = 1'b1;
            res.kind = EV_TEMPO;
            res.tempo_value = (tempo_sh == 32'd0) ? 32'd1 : tempo_sh;
            if (rem_dec == 32'd0) begin
              nxt.phase = PH_DELTA;
              nxt.delta_accum = 32'd0;
            end else begin
              nxt.phase = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (s0.meta_remaining != 32'd0) begin
            nxt.meta_remaining = rem_dec;
          end
          if (s0.meta_remaining == 32'd0 || rem_dec == 32'd0) begin
            nxt.phase = PH_DELTA;
            nxt.delta_accum = 32'd0;
          end
        end
        default: begin
          // delta phase: seven bits per byte, continuation in bit 7
          nxt.delta_accum = {s0.delta_accum[24:0], b7};
          nxt.phase = b[7] ? PH_DELTA : PH_STATUS;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/midi_track_event_parser_unit.sv]
// ---------------------------------------------------------------------------
// midi_track_event_parser_unit: track data event parser
// Parses a byte stream of track data into note, tempo and end events.
// ---------------------------------------------------------------------------
// Takes one track byte per clock on the in_ channel while in_stall is low and
// reports at most one event per byte on the out_ channel, in the cycle after
// the byte is taken. A byte is parsed combinationally by the step logic
// between the parser state registers and the output register, so the
// sustained rate is one byte per cycle; in_stall rises only while a
// finished event is held in the output register and out_stall is high.
// Bytes that complete no reportable event produce no request. Assert
// in_track_start on the first byte of each track; after an end-of-track
// event all bytes are dropped until the next track start. The silent
// channel register may be written at any time the block is idle.
`default_nettype none

module midi_track_event_parser_unit
  import mtep_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_track_start,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_kind,
  output logic [3:0]       out_channel,
  output logic [6:0]       out_note,
  output logic [6:0]       out_velocity,
  output logic [5:0]       out_volume,
  output logic [31:0]      out_delta_time,
  output logic [31:0]      out_tempo_value
);

  logic [4:0]   silent_ch_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  result_t      step_res;
  result_t      res_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  logic         in_accept;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  mtep_step u_step (
    .cur            (state_r),
    .track_start    (in_track_start),
    .data_byte      (in_data_byte),
    .silent_channel (silent_ch_r),
    .nxt            (state_nxt),
    .res            (step_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (in_accept) begin
      out_valid_nxt = step_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silent_ch_r <= SILENT_CH_RESET;
      state_r     <= PARSE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        silent_ch_r <= cfg_wr_data;
      end
      if (in_accept) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept && step_res.valid) begin
      res_r <= step_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_kind  = res_r.kind;
  assign out_channel     = res_r.channel;
  assign out_note        = res_r.note;
  assign out_velocity    = res_r.velocity;
  assign out_volume      = res_r.volume;
  assign out_delta_time  = res_r.delta_time;
  assign out_tempo_value = res_r.tempo_value;

  // nothing comes out after end of track until a new track starts
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_track_start && state_r.track_done) |=> !out_valid_r)
    else $error("event reported after end of track");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_kind == EV_TEMPO) |-> (out_tempo_value != 32'd0))
    else $error("tempo event with zero value");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_kind != EV_NOTE_ON) |-> (out_volume == 6'd0))
    else $error("volume set on non note-on event");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_track_start) |=> !state_r.track_done)
    else $error("track start did not clear end of track");

endmodule

`default_nettype wire
